// ----- rtl/core/jcs_pkg.sv -----
// Shared types, constants and helper functions for the joystick center scaling block.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package jcs_pkg;

    localparam int SMP_W   = 8;   // raw sample and center width
    localparam int POS_W   = 8;   // signed scaled position width
    localparam int DIR_W   = 2;
    localparam int QUO_W   = 7;   // quotient magnitude never exceeds 100
    localparam int CNT_W   = 3;   // indexes the quotient bits
    localparam int NUM_W   = 15;  // 255 * 100 fits in 15 bits
    localparam int CFG_IDX_W = 8;

    localparam int POS_SCALE  = 100;
    localparam int FULL_SCALE = 255;
    localparam int CENTER_RST = 128;

    localparam logic signed [POS_W-1:0] DIR_HI = 8'sd50;
    localparam logic signed [POS_W-1:0] DIR_LO = -8'sd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_CENTER = 8'd0,
        REG_Y_CENTER = 8'd1
    } t_reg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_NEUTRAL = 2'd0,
        DIR_POS     = 2'd1,
        DIR_NEG     = 2'd2
    } t_dir;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_DIV   = 5'b00100,
        S_STORE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } t_axis;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  setup;
        logic  step;
        logic  store;
        logic  emit;
        t_axis axis;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_sts;

    function automatic t_dir dir_of(input logic signed [POS_W-1:0] pos);
        t_dir d;
        if (pos > DIR_HI) begin
            d = DIR_POS;
        end else if (pos < DIR_LO) begin
            d = DIR_NEG;
        end else begin
            d = DIR_NEUTRAL;
        end
        return d;
    endfunction

endpackage

// ----- rtl/core/jcs_if.sv -----
// Valid/ready channel interfaces for sample requests, result requests and register writes.
// Depends on jcs_pkg for field widths.
interface jcs_in_if;
    logic                          valid;
    logic                          ready;
    logic [jcs_pkg::SMP_W-1:0]     x_sample;
    logic [jcs_pkg::SMP_W-1:0]     y_sample;
    logic [jcs_pkg::SMP_W-1:0]     right_sample;
    logic [jcs_pkg::SMP_W-1:0]     left_sample;

    modport source (output valid, x_sample, y_sample, right_sample, left_sample, input ready);
    modport sink   (input valid, x_sample, y_sample, right_sample, left_sample, output ready);
endinterface

interface jcs_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [jcs_pkg::POS_W-1:0]  x_pos;
    logic signed [jcs_pkg::POS_W-1:0]  y_pos;
    logic [jcs_pkg::DIR_W-1:0]         x_dir;
    logic [jcs_pkg::DIR_W-1:0]         y_dir;
    logic [jcs_pkg::SMP_W-1:0]         right_level;
    logic [jcs_pkg::SMP_W-1:0]         left_level;
    logic                              send;

    modport source (output valid, x_pos, y_pos, x_dir, y_dir, right_level, left_level, send,
                    input ready);
    modport sink   (input valid, x_pos, y_pos, x_dir, y_dir, right_level, left_level, send,
                    output ready);
endinterface

interface jcs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [jcs_pkg::CFG_IDX_W-1:0]     index;
    logic [jcs_pkg::SMP_W-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/jcs_ctrl.sv -----
// Sequencing state machine: accepts a sample request, runs the shared divider for X then Y,
// and hands the result to the output register. Depends on jcs_pkg.
module jcs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  jcs_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output jcs_pkg::t_cmd   o_cmd
);

    jcs_pkg::t_state r_state, n_state;
    jcs_pkg::t_axis  r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jcs_pkg::S_IDLE;
            r_axis  <= jcs_pkg::AXIS_X;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        o_cmd       = '0;
        o_cmd.axis  = r_axis;
        o_in_ready  = 1'b0;
        unique case (r_state)
            jcs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_axis     = jcs_pkg::AXIS_X;
                    n_state    = jcs_pkg::S_SETUP;
                end
            end
            jcs_pkg::S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = jcs_pkg::S_DIV;
            end
            jcs_pkg::S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = jcs_pkg::S_STORE;
                end
            end
            jcs_pkg::S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_axis == jcs_pkg::AXIS_X) begin
                    n_axis  = jcs_pkg::AXIS_Y;
                    n_state = jcs_pkg::S_SETUP;
                end else begin
                    n_state = jcs_pkg::S_OUT;
                end
            end
            jcs_pkg::S_OUT: begin
                // Wait here until the previous result has left the output register.
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = jcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jcs_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == jcs_pkg::S_SETUP && r_axis == jcs_pkg::AXIS_X))
        else $error("accepted request did not start the X axis");

    a_store_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.store && r_axis == jcs_pkg::AXIS_Y) |=> (r_state == jcs_pkg::S_OUT))
        else $error("Y axis store not followed by output");

endmodule

// ----- rtl/core/jcs_dp.sv -----
// Datapath: center registers, sample latch, shared restoring divider, change detection
// and the output register. Depends on jcs_pkg and jcs_out_if.
module jcs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jcs_pkg::t_cmd                 i_cmd,
    output jcs_pkg::t_sts                 o_sts,
    input  logic [jcs_pkg::SMP_W-1:0]     i_x_sample,
    input  logic [jcs_pkg::SMP_W-1:0]     i_y_sample,
    input  logic [jcs_pkg::SMP_W-1:0]     i_right_sample,
    input  logic [jcs_pkg::SMP_W-1:0]     i_left_sample,
    input  logic                          i_cfg_we,
    input  logic [jcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [jcs_pkg::SMP_W-1:0]     i_cfg_data,
    jcs_out_if.source                     o_out
);

    logic [jcs_pkg::SMP_W-1:0] r_x_center, r_y_center;
    logic [jcs_pkg::SMP_W-1:0] r_xs, r_ys, r_rs, r_ls;

    logic [jcs_pkg::NUM_W-1:0] r_rem;
    logic [jcs_pkg::SMP_W-1:0] r_den;
    logic [jcs_pkg::QUO_W-1:0] r_quo;
    logic [jcs_pkg::CNT_W-1:0] r_cnt;
    logic                      r_neg;

    logic signed [jcs_pkg::POS_W-1:0] r_xp, r_yp;

    logic signed [jcs_pkg::POS_W-1:0] r_last_x, r_last_y;
    logic [jcs_pkg::SMP_W-1:0]        r_last_right, r_last_left;
    logic                             r_have_last;

    logic                             r_out_valid;
    logic signed [jcs_pkg::POS_W-1:0] r_o_xp, r_o_yp;
    logic [jcs_pkg::DIR_W-1:0]        r_o_xdir, r_o_ydir;
    logic [jcs_pkg::SMP_W-1:0]        r_o_right, r_o_left;
    logic                             r_o_send;

    logic [jcs_pkg::SMP_W-1:0]        w_raw, w_ctr, w_mag, w_den;
    logic                             w_gt;
    logic [jcs_pkg::NUM_W-1:0]        w_num, w_trial;
    logic                             w_take;
    logic signed [jcs_pkg::POS_W-1:0] w_pos;
    logic                             w_changed;

    // Configuration registers; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_center <= jcs_pkg::SMP_W'(jcs_pkg::CENTER_RST);
            r_y_center <= jcs_pkg::SMP_W'(jcs_pkg::CENTER_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jcs_pkg::REG_X_CENTER: r_x_center <= i_cfg_data;
                jcs_pkg::REG_Y_CENTER: r_y_center <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Divider setup: the magnitude of the offset never exceeds the divisor, so the
    // quotient fits in seven bits and seven restoring steps suffice.
    always_comb begin
        w_raw = (i_cmd.axis == jcs_pkg::AXIS_Y) ? r_ys : r_xs;
        w_ctr = (i_cmd.axis == jcs_pkg::AXIS_Y) ? r_y_center : r_x_center;
        w_gt  = w_raw > w_ctr;
        w_mag = w_gt ? (w_raw - w_ctr) : (w_ctr - w_raw);
        w_den = w_gt ? (jcs_pkg::SMP_W'(jcs_pkg::FULL_SCALE) - w_ctr) : w_ctr;
        w_num = jcs_pkg::NUM_W'(w_mag) * jcs_pkg::NUM_W'(jcs_pkg::POS_SCALE);
    end

    // A zero divisor only occurs with a zero offset, where the position must be zero.
    assign w_trial = jcs_pkg::NUM_W'(r_den) << r_cnt;
    assign w_take  = (r_den != '0) && (r_rem >= w_trial);

    assign w_pos = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xs <= i_x_sample;
            r_ys <= i_y_sample;
            r_rs <= i_right_sample;
            r_ls <= i_left_sample;
        end
        if (i_cmd.setup) begin
            r_rem <= w_num;
            r_den <= w_den;
            r_neg <= !w_gt;
            r_quo <= '0;
            r_cnt <= jcs_pkg::CNT_W'(jcs_pkg::QUO_W - 1);
        end else if (i_cmd.step) begin
            if (w_take) begin
                r_rem        <= r_rem - w_trial;
                r_quo[r_cnt] <= 1'b1;
            end
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.store) begin
            if (i_cmd.axis == jcs_pkg::AXIS_Y) begin
                r_yp <= w_pos;
            end else begin
                r_xp <= w_pos;
            end
        end
    end

    assign w_changed = !r_have_last || (r_xp != r_last_x) || (r_yp != r_last_y) ||
                       (r_rs != r_last_right) || (r_ls != r_last_left);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_last_right <= '0;
            r_last_left  <= '0;
            r_have_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_last_x     <= r_xp;
                r_last_y     <= r_yp;
                r_last_right <= r_rs;
                r_last_left  <= r_ls;
                r_have_last  <= 1'b1;
                r_out_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_xp    <= r_xp;
            r_o_yp    <= r_yp;
            r_o_xdir  <= jcs_pkg::dir_of(r_xp);
            r_o_ydir  <= jcs_pkg::dir_of(r_yp);
            r_o_right <= r_rs;
            r_o_left  <= r_ls;
            r_o_send  <= w_changed;
        end
    end

    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.x_pos       = r_o_xp;
    assign o_out.y_pos       = r_o_yp;
    assign o_out.x_dir       = r_o_xdir;
    assign o_out.y_dir       = r_o_ydir;
    assign o_out.right_level = r_o_right;
    assign o_out.left_level  = r_o_left;
    assign o_out.send        = r_o_send;

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store |-> (r_quo <= jcs_pkg::QUO_W'(jcs_pkg::POS_SCALE)))
        else $error("scaled magnitude above full travel");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.out_free)
        else $error("result overwrote a pending output request");

    a_first_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_have_last) |=> (r_out_valid && r_o_send))
        else $error("first result after reset did not send");

endmodule

// ----- rtl/core/joystick_center_scale_change_detect_top.sv -----
// Requests are processed one at a time by the single seven-step divider, X then Y; the result
// is then registered, and no new request is taken until it reaches the output register.
// A finished result waits in the output register; the next request is taken meanwhile.
// Synchronous active-low reset: centers return to 128 and the next item always sends.
// Depends on jcs_pkg, jcs_if, jcs_ctrl and jcs_dp.
module joystick_center_scale_change_detect_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jcs_in_if.sink     i_in,
    jcs_cfg_if.sink    i_cfg,
    jcs_out_if.source  o_out
);

    jcs_pkg::t_cmd w_cmd;
    jcs_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    jcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    jcs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_x_sample     (i_in.x_sample),
        .i_y_sample     (i_in.y_sample),
        .i_right_sample (i_in.right_sample),
        .i_left_sample  (i_in.left_sample),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out          (o_out)
    );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for joystick_center_scale_change_detect_top: a directed table, then random
// phases under several center settings, each result checked against an in-bench predictor or a typed-in result.
// Depends on jcs_pkg, the jcs_if channel interfaces and the block's RTL.
module testbench;

    localparam int RANDOM_PHASES    = 7;
    localparam int ITEMS_PER_PHASE  = 170;
    localparam int STEADY_PHASE     = 5;
    localparam int HOLD_AFTER_ITEMS = 500;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int DIR_THRESHOLD    = 50;
    localparam logic [jcs_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;
    localparam logic [jcs_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = 8'd255;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        logic [jcs_pkg::SMP_W-1:0] x;
        logic [jcs_pkg::SMP_W-1:0] y;
        logic [jcs_pkg::SMP_W-1:0] right;
        logic [jcs_pkg::SMP_W-1:0] left;
    } t_joy_sample;

    typedef struct packed {
        logic signed [jcs_pkg::POS_W-1:0] x_pos;
        logic signed [jcs_pkg::POS_W-1:0] y_pos;
        jcs_pkg::t_dir                    x_dir;
        jcs_pkg::t_dir                    y_dir;
        logic [jcs_pkg::SMP_W-1:0]        right_level;
        logic [jcs_pkg::SMP_W-1:0]        left_level;
        logic                             send;
    } t_joy_report;

    typedef struct packed {
        t_row_kind                     kind;
        logic [jcs_pkg::CFG_IDX_W-1:0] index;
        logic [jcs_pkg::SMP_W-1:0]     data;
        t_joy_sample                   sample;
        logic                          typed;
        t_joy_report                   report;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    jcs_in_if  in_ch ();
    jcs_cfg_if cfg_ch ();
    jcs_out_if out_ch ();

    joystick_center_scale_change_detect_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of the centers and of the last reported values.
    logic [jcs_pkg::SMP_W-1:0]        x_center_model = jcs_pkg::SMP_W'(jcs_pkg::CENTER_RST);
    logic [jcs_pkg::SMP_W-1:0]        y_center_model = jcs_pkg::SMP_W'(jcs_pkg::CENTER_RST);
    logic signed [jcs_pkg::POS_W-1:0] prev_x_pos     = '0;
    logic signed [jcs_pkg::POS_W-1:0] prev_y_pos     = '0;
    logic [jcs_pkg::SMP_W-1:0]        prev_right     = '0;
    logic [jcs_pkg::SMP_W-1:0]        prev_left      = '0;
    bit                               seen_sample    = 1'b0;

    t_joy_report pending_reports[$];
    t_stim_row   directed_rows[$];
    t_joy_sample last_sample   = '0;
    int          samples_taken = 0;
    int          mismatch_count = 0;
    bit          hold_output   = 1'b0;
    bit          no_idle       = 1'b0;

    initial begin : run_limit
        #400000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic signed [jcs_pkg::POS_W-1:0] scale_to_percent(
        logic [jcs_pkg::SMP_W-1:0] raw, logic [jcs_pkg::SMP_W-1:0] ctr);
        int span;
        int quotient;
        if (raw > ctr) begin
            span = jcs_pkg::FULL_SCALE - int'(ctr);
        end else begin
            span = int'(ctr);
        end
        // A zero span only happens with the sample sitting on a zero center.
        if (span == 0) begin
            quotient = 0;
        end else begin
            quotient = ((int'(raw) - int'(ctr)) * jcs_pkg::POS_SCALE) / span;
        end
        return quotient[jcs_pkg::POS_W-1:0];
    endfunction

    function automatic jcs_pkg::t_dir direction_from(logic signed [jcs_pkg::POS_W-1:0] pos);
        if (pos > DIR_THRESHOLD) begin
            return jcs_pkg::DIR_POS;
        end else if (pos < -DIR_THRESHOLD) begin
            return jcs_pkg::DIR_NEG;
        end
        return jcs_pkg::DIR_NEUTRAL;
    endfunction

    function automatic t_joy_report predict_report(t_joy_sample s);
        t_joy_report r;
        r.x_pos       = scale_to_percent(s.x, x_center_model);
        r.y_pos       = scale_to_percent(s.y, y_center_model);
        r.x_dir       = direction_from(r.x_pos);
        r.y_dir       = direction_from(r.y_pos);
        r.right_level = s.right;
        r.left_level  = s.left;
        r.send        = !seen_sample || r.x_pos != prev_x_pos || r.y_pos != prev_y_pos ||
                        s.right != prev_right || s.left != prev_left;
        prev_x_pos  = r.x_pos;
        prev_y_pos  = r.y_pos;
        prev_right  = s.right;
        prev_left   = s.left;
        seen_sample = 1'b1;
        return r;
    endfunction

    function automatic void row_sample(int x, int y, int right, int left);
        t_stim_row row;
        row              = '0;
        row.kind         = ROW_SAMPLE;
        row.sample.x     = x[jcs_pkg::SMP_W-1:0];
        row.sample.y     = y[jcs_pkg::SMP_W-1:0];
        row.sample.right = right[jcs_pkg::SMP_W-1:0];
        row.sample.left  = left[jcs_pkg::SMP_W-1:0];
        directed_rows.push_back(row);
    endfunction

    // A row whose result is typed in; the sliders always pass straight through.
    function automatic void row_checked(int x, int y, int right, int left, int x_pos, int y_pos,
                                        jcs_pkg::t_dir x_dir, jcs_pkg::t_dir y_dir, bit send);
        t_stim_row row;
        row                    = '0;
        row.kind               = ROW_SAMPLE;
        row.sample.x           = x[jcs_pkg::SMP_W-1:0];
        row.sample.y           = y[jcs_pkg::SMP_W-1:0];
        row.sample.right       = right[jcs_pkg::SMP_W-1:0];
        row.sample.left        = left[jcs_pkg::SMP_W-1:0];
        row.typed              = 1'b1;
        row.report.x_pos       = x_pos[jcs_pkg::POS_W-1:0];
        row.report.y_pos       = y_pos[jcs_pkg::POS_W-1:0];
        row.report.x_dir       = x_dir;
        row.report.y_dir       = y_dir;
        row.report.right_level = right[jcs_pkg::SMP_W-1:0];
        row.report.left_level  = left[jcs_pkg::SMP_W-1:0];
        row.report.send        = send;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_write(logic [jcs_pkg::CFG_IDX_W-1:0] index, int data);
        t_stim_row row;
        row       = '0;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data[jcs_pkg::SMP_W-1:0];
        directed_rows.push_back(row);
    endfunction

    function automatic logic [jcs_pkg::SMP_W-1:0] draw_axis(logic [jcs_pkg::SMP_W-1:0] ctr);
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = jcs_pkg::FULL_SCALE;
            2: v = int'(ctr);
            3: begin
                v = int'(ctr) + int'($urandom_range(0, 12)) - 6;
                if (v < 0) begin
                    v = 0;
                end
                if (v > jcs_pkg::FULL_SCALE) begin
                    v = jcs_pkg::FULL_SCALE;
                end
            end
            default: v = int'($urandom_range(0, jcs_pkg::FULL_SCALE));
        endcase
        return v[jcs_pkg::SMP_W-1:0];
    endfunction

    // Repeats and single-slider changes keep the no-change path busy.
    function automatic t_joy_sample draw_sample(t_joy_sample prev);
        t_joy_sample s;
        s = prev;
        case ($urandom_range(0, 9))
            0, 1: ;
            2: s.right = 8'($urandom);
            3: s.left = 8'($urandom);
            default: begin
                s.x     = draw_axis(x_center_model);
                s.y     = draw_axis(y_center_model);
                s.right = 8'($urandom);
                s.left  = 8'($urandom);
            end
        endcase
        return s;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Centers may only change with nothing in flight, so drain first.
    task automatic write_register(logic [jcs_pkg::CFG_IDX_W-1:0] index,
                                  logic [jcs_pkg::SMP_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (index == jcs_pkg::REG_X_CENTER) begin
            x_center_model = value;
        end else if (index == jcs_pkg::REG_Y_CENTER) begin
            y_center_model = value;
        end
        @(posedge i_clk);
    endtask

    // Leaves valid high on return so that back-to-back requests need no extra edge.
    task automatic offer_sample(t_joy_sample s, logic typed, t_joy_report typed_report);
        int          gap;
        t_joy_report want;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.x_sample     <= s.x;
        in_ch.y_sample     <= s.y;
        in_ch.right_sample <= s.right;
        in_ch.left_sample  <= s.left;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        want = predict_report(s);
        if (typed) begin
            want = typed_report;
        end
        pending_reports.push_back(want);
        samples_taken++;
        last_sample = s;
    endtask

    initial begin : report_sink
        int          stall;
        t_joy_report want;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0 || hold_output) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                while (hold_output) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected request, x_pos", out_ch.x_pos, 0);
            end else begin
                want = pending_reports.pop_front();
                if (out_ch.x_pos !== want.x_pos)
                    report_mismatch("x_pos", out_ch.x_pos, want.x_pos);
                if (out_ch.y_pos !== want.y_pos)
                    report_mismatch("y_pos", out_ch.y_pos, want.y_pos);
                if (out_ch.x_dir !== want.x_dir)
                    report_mismatch("x_dir", out_ch.x_dir, want.x_dir);
                if (out_ch.y_dir !== want.y_dir)
                    report_mismatch("y_dir", out_ch.y_dir, want.y_dir);
                if (out_ch.right_level !== want.right_level)
                    report_mismatch("right_level", out_ch.right_level, want.right_level);
                if (out_ch.left_level !== want.left_level)
                    report_mismatch("left_level", out_ch.left_level, want.left_level);
                if (out_ch.send !== want.send)
                    report_mismatch("send", out_ch.send, want.send);
            end
        end
    end

    // One long stall on the result side while requests keep coming, to back up the input.
    initial begin : output_hold
        while (samples_taken < HOLD_AFTER_ITEMS) @(posedge i_clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    initial begin : stimulus
        int                        phase;
        logic [jcs_pkg::SMP_W-1:0] x_ctr;
        logic [jcs_pkg::SMP_W-1:0] y_ctr;

        in_ch.valid        = 1'b0;
        in_ch.x_sample     = '0;
        in_ch.y_sample     = '0;
        in_ch.right_sample = '0;
        in_ch.left_sample  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;

        // Reset centers: the first request sends even though it matches the cleared state.
        row_checked(128, 128, 0, 0, 0, 0, jcs_pkg::DIR_NEUTRAL, jcs_pkg::DIR_NEUTRAL, 1'b1);
        row_checked(128, 128, 0, 0, 0, 0, jcs_pkg::DIR_NEUTRAL, jcs_pkg::DIR_NEUTRAL, 1'b0);
        row_checked(255, 0, 255, 255, 100, -100, jcs_pkg::DIR_POS, jcs_pkg::DIR_NEG, 1'b1);
        row_checked(0, 255, 8'hAA, 8'h55, -100, 100, jcs_pkg::DIR_NEG, jcs_pkg::DIR_POS, 1'b1);
        row_sample(192, 64, 1, 2);
        row_sample(193, 63, 1, 2);
        row_sample(64, 192, 1, 2);
        row_sample(128, 128, 1, 3);
        // Zero center on X, full-scale center on Y.
        row_write(jcs_pkg::REG_X_CENTER, 0);
        row_write(jcs_pkg::REG_Y_CENTER, 255);
        row_checked(0, 255, 7, 7, 0, 0, jcs_pkg::DIR_NEUTRAL, jcs_pkg::DIR_NEUTRAL, 1'b1);
        row_checked(255, 0, 7, 7, 100, -100, jcs_pkg::DIR_POS, jcs_pkg::DIR_NEG, 1'b1);
        row_sample(1, 128, 7, 7);
        row_write(jcs_pkg::REG_X_CENTER, 255);
        row_write(jcs_pkg::REG_Y_CENTER, 0);
        row_checked(255, 0, 9, 9, 0, 0, jcs_pkg::DIR_NEUTRAL, jcs_pkg::DIR_NEUTRAL, 1'b1);
        row_checked(0, 255, 9, 9, -100, 100, jcs_pkg::DIR_NEG, jcs_pkg::DIR_POS, 1'b1);
        // Writes to unused indexes must leave both centers alone.
        row_write(REG_FIRST_UNUSED, 77);
        row_write(REG_LAST_UNUSED, 0);
        row_checked(0, 255, 9, 9, -100, 100, jcs_pkg::DIR_NEG, jcs_pkg::DIR_POS, 1'b0);
        // Divisor of one on each side of the center.
        row_write(jcs_pkg::REG_X_CENTER, 1);
        row_write(jcs_pkg::REG_Y_CENTER, 254);
        row_checked(0, 255, 9, 9, -100, 100, jcs_pkg::DIR_NEG, jcs_pkg::DIR_POS, 1'b0);
        row_sample(2, 253, 9, 9);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                write_register(directed_rows[i].index, directed_rows[i].data);
            end else begin
                offer_sample(directed_rows[i].sample, directed_rows[i].typed,
                             directed_rows[i].report);
            end
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                1: begin
                    x_ctr = 8'd0;
                    y_ctr = 8'd255;
                end
                2: begin
                    x_ctr = 8'd255;
                    y_ctr = 8'd0;
                end
                3: begin
                    x_ctr = 8'd0;
                    y_ctr = 8'd0;
                end
                4: begin
                    x_ctr = 8'd255;
                    y_ctr = 8'd255;
                end
                6: begin
                    x_ctr = 8'(jcs_pkg::CENTER_RST);
                    y_ctr = 8'(jcs_pkg::CENTER_RST);
                end
                default: begin
                    x_ctr = 8'($urandom);
                    y_ctr = 8'($urandom);
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_register(8'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                               8'($urandom));
            end
            write_register(jcs_pkg::REG_X_CENTER, x_ctr);
            write_register(jcs_pkg::REG_Y_CENTER, y_ctr);
            no_idle = (phase == STEADY_PHASE);
            repeat (ITEMS_PER_PHASE) offer_sample(draw_sample(last_sample), 1'b0, '0);
        end
        no_idle = 1'b0;

        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
